// File: design/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// shared types, tags, status codes and format checks of the wav stream decoder
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam logic [31:0] TAG_RIFF   = 32'h52494646;
  localparam logic [31:0] TAG_WAVE   = 32'h57415645;
  localparam logic [31:0] TAG_FMT    = 32'h666D7420;
  localparam logic [31:0] TAG_DATA   = 32'h64617461;
  localparam logic [15:0] EXTENSIBLE = 16'hFFFE;
  localparam int unsigned MIN_FILE   = 44;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_NOT_WAVE  = 4'd2;
  localparam logic [3:0] ST_TRUNC     = 4'd3;
  localparam logic [3:0] ST_NO_FMT    = 4'd4;
  localparam logic [3:0] ST_NO_DATA   = 4'd5;
  localparam logic [3:0] ST_FORMAT    = 4'd6;
  localparam logic [3:0] ST_CHANNELS  = 4'd7;
  localparam logic [3:0] ST_BITS      = 4'd8;
  localparam logic [3:0] ST_FLOAT_BAD = 4'd9;
  localparam logic [3:0] ST_NO_FRAMES = 4'd10;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    SEL_16 = 2'd0,
    SEL_24 = 2'd1,
    SEL_32 = 2'd2
  } width_sel_t;

  // one queue entry: an optional frame, then an optional final report
  typedef struct packed {
    logic        has_frame;
    logic [31:0] left_raw;
    logic [31:0] right_raw;
    logic        is_float;
    width_sel_t  wsel;
    logic        has_report;
    logic [3:0]  status;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [31:0] frames;
  } entry_t;

  function automatic logic fmt_usable(input logic [15:0] f, input logic [15:0] c,
                                      input logic [15:0] b);
    logic ok;
    ok = (f == FMT_PCM || f == FMT_FLOAT) && (c == 16'd1 || c == 16'd2) &&
         (b == 16'd16 || b == 16'd24 || b == 16'd32) &&
         !(f == FMT_FLOAT && b != 16'd32);
    return ok;
  endfunction

  function automatic logic [3:0] final_status(
      input logic short_file, input logic bad_tag, input logic data_cut,
      input logic fmt_cut, input logic data_seen, input logic [15:0] f,
      input logic [15:0] c, input logic [15:0] b, input logic [31:0] frames);
    logic [3:0] st;
    if (short_file) st = ST_SHORT;
    else if (bad_tag) st = ST_NOT_WAVE;
    else if (data_cut) st = ST_TRUNC;
    else if (fmt_cut || f == 16'd0 || c == 16'd0) st = ST_NO_FMT;
    else if (!data_seen) st = ST_NO_DATA;
    else if (f != FMT_PCM && f != FMT_FLOAT) st = ST_FORMAT;
    else if (c != 16'd1 && c != 16'd2) st = ST_CHANNELS;
    else if (b != 16'd16 && b != 16'd24 && b != 16'd32) st = ST_BITS;
    else if (f == FMT_FLOAT && b != 16'd32) st = ST_FLOAT_BAD;
    else if (frames == 32'd0) st = ST_NO_FRAMES;
    else st = ST_OK;
    return st;
  endfunction

endpackage

// File: design/wss_parser.sv
// ----------------------------------------------------------------------------
// wss_parser
// front part: walks the riff chunks byte by byte and builds queue entries
// ----------------------------------------------------------------------------
module wss_parser #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      file_byte,
  input  logic            final_byte,
  output logic            push,
  output wss_pkg::entry_t push_entry
);

  typedef enum logic [4:0] {
    PH_FILEHDR  = 5'b00001,
    PH_CHUNKHDR = 5'b00010,
    PH_BODY     = 5'b00100,
    PH_DECODE   = 5'b01000,
    PH_STOP     = 5'b10000
  } phase_t;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  phase_t                    phase_r, phase_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [31:0] tag_r, tag_nxt, len_r, len_nxt, rem_r, rem_nxt;
  logic [15:0] fmt_r, fmt_nxt, chan_r, chan_nxt, bits_r, bits_nxt;
  logic [31:0] rate_r, rate_nxt, asm_r, asm_nxt, held_r, held_nxt;
  logic [31:0] frames_r, frames_nxt;
  logic [1:0]  bidx_r, bidx_nxt;
  logic        ch_r, ch_nxt, seen_r, seen_nxt, bad_r, bad_nxt, pad_r, pad_nxt;

  logic [2:0]  k;
  logic [31:0] off, asm_new;
  logic [1:0]  last_idx;
  logic        cut, fmt_cut;
  logic [3:0]  st;

  always_comb begin
    phase_nxt = phase_r;  pos_nxt = pos_r;    tag_nxt = tag_r;
    len_nxt = len_r;      rem_nxt = rem_r;    fmt_nxt = fmt_r;
    chan_nxt = chan_r;    bits_nxt = bits_r;  rate_nxt = rate_r;
    asm_nxt = asm_r;      held_nxt = held_r;  frames_nxt = frames_r;
    bidx_nxt = bidx_r;    ch_nxt = ch_r;      seen_nxt = seen_r;
    bad_nxt = bad_r;      pad_nxt = pad_r;
    push = 1'b0;
    push_entry = '0;
    k = rem_r[2:0];
    off = len_r - rem_r;
    asm_new = asm_r;
    last_idx = 2'd3;
    cut = 1'b0;
    fmt_cut = 1'b0;
    st = wss_pkg::ST_OK;
    if (step) begin
      if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;
      unique case (phase_r)
        PH_FILEHDR: begin
          if (pos_r < POSITION_WIDTH'(4) ||
              (pos_r >= POSITION_WIDTH'(8) && pos_r < POSITION_WIDTH'(12)))
            tag_nxt = {tag_r[23:0], file_byte};
          if (pos_r == POSITION_WIDTH'(3) && tag_nxt != wss_pkg::TAG_RIFF) begin
            bad_nxt = 1'b1;
            phase_nxt = PH_STOP;
          end else if (pos_r == POSITION_WIDTH'(11)) begin
            if (tag_nxt != wss_pkg::TAG_WAVE) begin
              bad_nxt = 1'b1;
              phase_nxt = PH_STOP;
            end else begin
              phase_nxt = PH_CHUNKHDR;
              rem_nxt = '0;
              pad_nxt = 1'b0;
            end
          end
        end
        PH_CHUNKHDR: begin
          if (pad_r) begin
            pad_nxt = 1'b0;
          end else begin
            case (k)
              3'd4:    len_nxt = {24'd0, file_byte};
              3'd5:    len_nxt[15:8] = file_byte;
              3'd6:    len_nxt[23:16] = file_byte;
              3'd7:    len_nxt[31:24] = file_byte;
              default: tag_nxt = {tag_r[23:0], file_byte};
            endcase
            rem_nxt = {29'd0, k} + 32'd1;
            if (k == 3'd7) begin
              // chunk body begins
              rem_nxt = len_nxt;
              phase_nxt = PH_BODY;
              if (tag_r == wss_pkg::TAG_DATA && !seen_r) begin
                seen_nxt = 1'b1;
                if (wss_pkg::fmt_usable(fmt_r, chan_r, bits_r)) begin
                  phase_nxt = PH_DECODE;
                  asm_nxt = '0;
                  bidx_nxt = '0;
                  ch_nxt = 1'b0;
                end
              end
              if (len_nxt == 32'd0) begin
                pad_nxt = 1'b0;
                phase_nxt = PH_CHUNKHDR;
                rem_nxt = '0;
              end
            end
          end
        end
        PH_BODY, PH_DECODE: begin
          if (rem_r == 32'd0) begin
            pad_nxt = len_r[0];
            phase_nxt = PH_CHUNKHDR;
          end else begin
            if (phase_r == PH_DECODE) begin
              case (bidx_r)
                2'd0:    asm_new = {24'd0, file_byte};
                2'd1:    asm_new = asm_r | {16'd0, file_byte, 8'd0};
                2'd2:    asm_new = asm_r | {8'd0, file_byte, 16'd0};
                default: asm_new = asm_r | {file_byte, 24'd0};
              endcase
              asm_nxt = asm_new;
              if (bits_r == 16'd16) last_idx = 2'd1;
              else if (bits_r == 16'd24) last_idx = 2'd2;
              if (bidx_r != last_idx) begin
                bidx_nxt = bidx_r + 2'd1;
              end else begin
                bidx_nxt = '0;
                push_entry.left_raw = asm_new;
                push_entry.right_raw = asm_new;
                push_entry.is_float = (fmt_r == wss_pkg::FMT_FLOAT);
                push_entry.wsel = (bits_r == 16'd16) ? wss_pkg::SEL_16 :
                                  (bits_r == 16'd24) ? wss_pkg::SEL_24 : wss_pkg::SEL_32;
                if (chan_r == 16'd1 || ch_r) begin
                  if (chan_r != 16'd1) push_entry.left_raw = held_r;
                  ch_nxt = 1'b0;
                  push_entry.has_frame = 1'b1;
                  if (frames_r != 32'hFFFF_FFFF) frames_nxt = frames_r + 32'd1;
                end else begin
                  held_nxt = asm_new;
                  ch_nxt = 1'b1;
                end
              end
            end else if (tag_r == wss_pkg::TAG_FMT && !seen_r && len_r >= 32'd16) begin
              case (off)
                32'd0:  fmt_nxt = {8'd0, file_byte};
                32'd1:  fmt_nxt[15:8] = file_byte;
                32'd2:  chan_nxt = {8'd0, file_byte};
                32'd3:  chan_nxt[15:8] = file_byte;
                32'd4:  rate_nxt = {24'd0, file_byte};
                32'd5:  rate_nxt[15:8] = file_byte;
                32'd6:  rate_nxt[23:16] = file_byte;
                32'd7:  rate_nxt[31:24] = file_byte;
                32'd14: bits_nxt = {8'd0, file_byte};
                32'd15: bits_nxt[15:8] = file_byte;
                32'd24: asm_nxt = {24'd0, file_byte};
                32'd25: begin
                  // extensible header: real format tag from the sub-format guid
                  if (fmt_r == wss_pkg::EXTENSIBLE && len_r >= 32'd40)
                    fmt_nxt = {file_byte, asm_r[7:0]};
                end
                default: ;
              endcase
            end
            rem_nxt = rem_r - 32'd1;
            if (rem_r == 32'd1) begin
              pad_nxt = len_r[0];
              phase_nxt = PH_CHUNKHDR;
            end
          end
        end
        PH_STOP: ;
        default: ;
      endcase

      if (final_byte) begin
        cut = (phase_nxt == PH_BODY || phase_nxt == PH_DECODE) && rem_nxt != 32'd0;
        fmt_cut = cut && tag_nxt == wss_pkg::TAG_FMT && !seen_nxt;
        st = wss_pkg::final_status(pos_nxt < POSITION_WIDTH'(wss_pkg::MIN_FILE), bad_nxt,
                                   cut && tag_nxt == wss_pkg::TAG_DATA, fmt_cut, seen_nxt,
                                   fmt_nxt, chan_nxt, bits_nxt, frames_nxt);
        push_entry.has_report = 1'b1;
        push_entry.status = st;
        if (st == wss_pkg::ST_OK) begin
          push_entry.rate = rate_nxt;
          push_entry.channels = chan_nxt;
          push_entry.frames = frames_nxt;
        end
        // back to the reset state for the next file
        phase_nxt = PH_FILEHDR;  pos_nxt = '0;  tag_nxt = '0;  len_nxt = '0;
        rem_nxt = '0;  fmt_nxt = '0;  chan_nxt = '0;  bits_nxt = '0;  rate_nxt = '0;
        asm_nxt = '0;  held_nxt = '0;  frames_nxt = '0;  bidx_nxt = '0;  ch_nxt = 1'b0;
        seen_nxt = 1'b0;  bad_nxt = 1'b0;  pad_nxt = 1'b0;
      end
      push = push_entry.has_frame | push_entry.has_report;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILEHDR;  pos_r <= '0;  tag_r <= '0;  len_r <= '0;  rem_r <= '0;
      fmt_r <= '0;  chan_r <= '0;  bits_r <= '0;  rate_r <= '0;  asm_r <= '0;
      held_r <= '0;  frames_r <= '0;  bidx_r <= '0;  ch_r <= 1'b0;  seen_r <= 1'b0;
      bad_r <= 1'b0;  pad_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;  pos_r <= pos_nxt;  tag_r <= tag_nxt;  len_r <= len_nxt;
      rem_r <= rem_nxt;  fmt_r <= fmt_nxt;  chan_r <= chan_nxt;  bits_r <= bits_nxt;
      rate_r <= rate_nxt;  asm_r <= asm_nxt;  held_r <= held_nxt;
      frames_r <= frames_nxt;  bidx_r <= bidx_nxt;  ch_r <= ch_nxt;
      seen_r <= seen_nxt;  bad_r <= bad_nxt;  pad_r <= pad_nxt;
    end
  end

endmodule

// File: design/wss_fifo.sv
// ----------------------------------------------------------------------------
// wss_fifo
// short entry queue between the parser and the converter
// ----------------------------------------------------------------------------
module wss_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wss_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output wss_pkg::entry_t head
);

  localparam int PW = $clog2(wss_pkg::FIFO_DEPTH);

  wss_pkg::entry_t mem_r [wss_pkg::FIFO_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign full      = (cnt_r == (PW+1)'(wss_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// File: design/wss_convert.sv
// ----------------------------------------------------------------------------
// wss_convert
// back part: pcm to single conversion in two stages, stage 1 and the output register
// ----------------------------------------------------------------------------
module wss_convert (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            not_empty,
  input  wss_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_kind,
  output logic [31:0]     out_left,
  output logic [31:0]     out_right,
  output logic [3:0]      out_status,
  output logic [31:0]     out_rate,
  output logic [15:0]     out_channels,
  output logic [31:0]     out_frames,
  output logic            out_last
);

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [31:0] mag;
    logic [4:0]  msb;
  } norm_t;

  function automatic norm_t front_norm(input logic [31:0] raw, input wss_pkg::width_sel_t w);
    norm_t n;
    logic [31:0] sx;
    case (w)
      wss_pkg::SEL_16: sx = {{16{raw[15]}}, raw[15:0]};
      wss_pkg::SEL_24: sx = {{8{raw[23]}}, raw[23:0]};
      default:         sx = raw;
    endcase
    n.sign = sx[31];
    n.mag  = sx[31] ? (~sx + 32'd1) : sx;
    n.zero = (n.mag == 32'd0);
    n.msb  = '0;
    for (int i = 0; i < 32; i++) begin
      if (n.mag[i]) n.msb = 5'(i);
    end
    return n;
  endfunction

  function automatic logic [31:0] back_norm(input norm_t n, input wss_pkg::width_sel_t w);
    logic [8:0]  ex;
    logic [4:0]  sh;
    logic [24:0] m;
    logic [31:0] rem, half, shifted;
    case (w)
      wss_pkg::SEL_16: ex = 9'(n.msb) + 9'd112;
      wss_pkg::SEL_24: ex = 9'(n.msb) + 9'd104;
      default:         ex = 9'(n.msb) + 9'd96;
    endcase
    sh = '0;
    rem = '0;
    half = '0;
    if (n.msb <= 5'd23) begin
      shifted = n.mag << (5'd23 - n.msb);
      m = {1'b0, shifted[23:0]};
    end else begin
      sh = n.msb - 5'd23;
      shifted = n.mag >> sh;
      m = {1'b0, shifted[23:0]};
      rem = n.mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && m[0])) m = m + 25'd1;
      if (m[24]) begin
        m = m >> 1;
        ex = ex + 9'd1;
      end
    end
    if (n.zero) return 32'd0;
    return {n.sign, ex[7:0], m[22:0]};
  endfunction

  // stage 1
  logic        s1_valid_r, s1_kind_r, s1_float_r, s1_last_r;
  wss_pkg::width_sel_t s1_wsel_r;
  norm_t       s1_l_r, s1_r_r;
  logic [31:0] s1_lraw_r, s1_rraw_r, s1_rate_r, s1_frames_r;
  logic [3:0]  s1_status_r;
  logic [15:0] s1_chan_r;
  logic        split_r;

  // output register
  logic        out_valid_r, out_kind_r, out_last_r;
  logic [31:0] out_left_r, out_right_r, out_rate_r, out_frames_r;
  logic [3:0]  out_status_r;
  logic [15:0] out_chan_r;

  logic adv, load, take_frame;

  assign adv        = !out_valid_r || out_ready;
  assign load       = not_empty && (!s1_valid_r || adv);
  assign take_frame = head.has_frame && !split_r;
  assign pop        = load && !(take_frame && head.has_report);

  always_ff @(posedge clk) begin
    if (load) begin
      s1_kind_r   <= !take_frame;
      s1_float_r  <= head.is_float;
      s1_wsel_r   <= head.wsel;
      s1_lraw_r   <= head.left_raw;
      s1_rraw_r   <= head.right_raw;
      s1_l_r      <= front_norm(head.left_raw, head.wsel);
      s1_r_r      <= front_norm(head.right_raw, head.wsel);
      s1_status_r <= head.status;
      s1_rate_r   <= head.rate;
      s1_chan_r   <= head.channels;
      s1_frames_r <= head.frames;
      s1_last_r   <= !take_frame;
    end
    if (s1_valid_r && adv) begin
      out_kind_r <= s1_kind_r;
      out_last_r <= s1_last_r;
      if (s1_kind_r) begin
        out_left_r   <= '0;
        out_right_r  <= '0;
        out_status_r <= s1_status_r;
        out_rate_r   <= s1_rate_r;
        out_chan_r   <= s1_chan_r;
        out_frames_r <= s1_frames_r;
      end else begin
        out_left_r   <= s1_float_r ? s1_lraw_r : back_norm(s1_l_r, s1_wsel_r);
        out_right_r  <= s1_float_r ? s1_rraw_r : back_norm(s1_r_r, s1_wsel_r);
        out_status_r <= '0;
        out_rate_r   <= '0;
        out_chan_r   <= '0;
        out_frames_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      split_r     <= 1'b0;
    end else begin
      if (load) s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv) out_valid_r <= s1_valid_r;
      if (load) split_r <= take_frame && head.has_report;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_left     = out_left_r;
  assign out_right    = out_right_r;
  assign out_status   = out_status_r;
  assign out_rate     = out_rate_r;
  assign out_channels = out_chan_r;
  assign out_frames   = out_frames_r;
  assign out_last     = out_last_r;

endmodule

// File: design/wav_stream_sample_decoder.sv
// ----------------------------------------------------------------------------
// wav_stream_sample_decoder
// riff/wave byte stream parser emitting stereo ieee single frames and a report
// ----------------------------------------------------------------------------
// path: out_tvalid rises once the byte that ends a frame or the file has passed
//   the queue write, the conversion stage and the output register
// throughput: one byte per cycle while the queue has room; the converter gives
//   one result per cycle unless out_tready stalls; a frame-ending last byte gives two
// reset: rst_n synchronous active low clears parser, queue and output stage;
//   after a byte with in_tlast the parser returns to its reset state by itself
// ----------------------------------------------------------------------------
module wav_stream_sample_decoder #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] file_byte
  input  logic         in_tlast,   // final_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // [31:0] left_sample, [63:32] right_sample,
                                   // [67:64] status, [99:68] sample_rate,
                                   // [115:100] channel_count, [147:116] frame_count,
                                   // [151:148] zero
  output logic         out_tuser,  // kind
  output logic         out_tlast   // is_last
);

  logic            step, push, full, pop, not_empty;
  wss_pkg::entry_t push_entry, head;
  logic [31:0]     left, right, rate, frames;
  logic [3:0]      status;
  logic [15:0]     chans;

  // a byte transfers whenever the queue has a free slot
  assign in_tready = !full;
  assign step      = in_tvalid && in_tready;

  // front: header and chunk walk, fmt capture, sample assembly
  wss_parser #(.POSITION_WIDTH(POSITION_WIDTH)) u_parser (
    .clk, .rst_n, .step, .file_byte(in_tdata), .final_byte(in_tlast),
    .push, .push_entry
  );

  // queue decouples parsing from conversion and output stalls
  wss_fifo u_fifo (
    .clk, .rst_n, .push, .push_entry, .full, .pop, .not_empty, .head
  );

  // back: pcm to single in two stages, stage 1 and the output register
  wss_convert u_convert (
    .clk, .rst_n, .not_empty, .head, .pop,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_kind(out_tuser),
    .out_left(left), .out_right(right), .out_status(status), .out_rate(rate),
    .out_channels(chans), .out_frames(frames), .out_last(out_tlast)
  );

  assign out_tdata = {4'd0, frames, chans, rate, status, right, left};

endmodule
